@@ hw/rtl/mrbs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrbs_pkg
// Shared types and field widths for the longest mountain subsequence block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrbs_pkg;

  localparam int VALUE_W = 32;
  localparam int OUT_W   = 7;

  typedef enum logic [1:0] {
    T_LOAD,
    T_RUN,
    T_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_R_HEAD,
    E_R_FIRST,
    E_R_ROW,
    E_F_HEAD,
    E_F_FIRST,
    E_F_ROW,
    E_DONE
  } eng_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/mrbs_if.sv @@
// ----------------------------------------------------------------------------
// mrbs_in_if / mrbs_out_if
// Valid/ready channels for sequence elements and for mountain results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrbs_in_if;
  import mrbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mrbs_out_if;
  import mrbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] removals;
  logic [OUT_W-1:0] mountain_length;
  logic             overflow;

  modport source (output valid, output removals, output mountain_length,
                  output overflow, input ready);
  modport sink   (input valid, input removals, input mountain_length,
                  input overflow, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/min_removals_bitonic_subsequence.sv @@
// ----------------------------------------------------------------------------
// min_removals_bitonic_subsequence
// Longest mountain subsequence and minimum removals over a loaded sequence.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while loading; up to MAX_LEN are kept and
// further ones are dropped and flagged. The transfer with last set closes the
// sequence and starts the DP, during which no element is taken. Every step of
// the rise and fall passes is one read of the value memory and of the length
// memory and one compare, with one write-back per row. Elements are refused
// from the last transfer until the result is registered, longer if the
// previous result has not been taken yet. One result follows; the next
// sequence can load while that result waits to be taken.
`default_nettype none

module min_removals_bitonic_subsequence #(
  parameter int MAX_LEN = 64
) (
  input wire logic clk,
  input wire logic rst,
  mrbs_in_if.sink    items,
  mrbs_out_if.source results
);
  import mrbs_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int EXT_W = (CNT_W > OUT_W) ? CNT_W : OUT_W;

  top_state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             ovf, ovf_next;
  logic             fire;
  logic             store_en;
  logic             start;
  logic             done;
  logic [CNT_W-1:0] best;
  logic [EXT_W-1:0] diff_ext;
  logic [EXT_W-1:0] best_ext;
  logic             emit;

  assign items.ready = (state == T_LOAD);
  assign fire        = items.valid && items.ready;
  assign diff_ext    = EXT_W'(count - best);
  assign best_ext    = EXT_W'(best);

  mrbs_engine #(
    .MAX_LEN (MAX_LEN),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .store_en    (store_en),
    .store_addr  (count[IDX_W-1:0]),
    .store_value (items.value),
    .start       (start),
    .seq_len     (count_next),
    .done        (done),
    .best        (best)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    store_en   = 1'b0;
    start      = 1'b0;
    emit       = 1'b0;
    case (state)
      T_LOAD: begin
        if (fire) begin
          if (count < CNT_W'(MAX_LEN)) begin
            store_en   = 1'b1;
            count_next = CNT_W'(count + 1'b1);
          end else begin
            ovf_next = 1'b1;
          end
          if (items.last) begin
            start      = 1'b1;
            state_next = T_RUN;
          end
        end
      end
      T_RUN: begin
        if (done) begin
          state_next = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!results.valid || results.ready) begin
          emit       = 1'b1;
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = T_LOAD;
        end
      end
      default: begin
        state_next = T_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_LOAD;
      count         <= '0;
      ovf           <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      if (emit) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
    if (emit) begin
      results.removals        <= diff_ext[OUT_W-1:0];
      results.mountain_length <= best_ext[OUT_W-1:0];
      results.overflow        <= ovf;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mrbs_engine.sv @@
// ----------------------------------------------------------------------------
// mrbs_engine
// Element store and quadratic rise/fall DP. One read per cycle on each of the
// value and length memories; a length entry holds the rise and fall lengths
// of one position. Best peak length accumulated during the fall pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mrbs_engine #(
  parameter int MAX_LEN = 64,
  parameter int IDX_W   = 6,
  parameter int CNT_W   = 7
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               store_en,
  input  wire logic [IDX_W-1:0]                   store_addr,
  input  wire logic signed [mrbs_pkg::VALUE_W-1:0] store_value,
  input  wire logic                               start,
  input  wire logic [CNT_W-1:0]                   seq_len,
  output logic                                    done,
  output logic [CNT_W-1:0]                        best
);
  import mrbs_pkg::*;

  logic signed [VALUE_W-1:0] value_mem [MAX_LEN];
  logic [2*CNT_W-1:0]        len_mem   [MAX_LEN];

  eng_state_t state, state_next;
  logic [IDX_W-1:0] p, p_next;
  logic [CNT_W-1:0] q, q_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] ri, ri_next;
  logic [CNT_W-1:0] best_next;
  logic signed [VALUE_W-1:0] vp, vp_next;

  logic [IDX_W-1:0]          val_raddr, len_raddr;
  logic signed [VALUE_W-1:0] val_rdata;
  logic [2*CNT_W-1:0]        len_rdata;
  logic [CNT_W-1:0]          rise_rdata, fall_rdata;
  logic                      rise_we, fall_we;
  logic [CNT_W-1:0]          len_wdata;
  logic [2*CNT_W-1:0]        mem_wdata;

  logic             lt_rise, lt_fall;
  logic [CNT_W-1:0] rise_eff, fall_eff;
  logic [CNT_W:0]   peak_sum;
  logic [CNT_W-1:0] peak_len;
  logic [CNT_W-1:0] ri_use;

  always_ff @(posedge clk) begin
    if (store_en) begin
      value_mem[store_addr] <= store_value;
    end
    val_rdata <= value_mem[val_raddr];
  end

  // upper half rise length, lower half fall length
  always_ff @(posedge clk) begin
    if (rise_we || fall_we) begin
      len_mem[p] <= mem_wdata;
    end
    len_rdata <= len_mem[len_raddr];
  end

  assign rise_rdata = len_rdata[2*CNT_W-1:CNT_W];
  assign fall_rdata = len_rdata[CNT_W-1:0];
  assign mem_wdata  = rise_we ? {len_wdata, CNT_W'(0)} : {ri_use, len_wdata};

  // vq < vp with the stored length able to extend the current one
  assign lt_rise  = (val_rdata < vp) && (rise_rdata >= cur);
  assign lt_fall  = (val_rdata < vp) && (fall_rdata >= cur);
  assign rise_eff = lt_rise ? CNT_W'(rise_rdata + 1'b1) : cur;
  assign fall_eff = lt_fall ? CNT_W'(fall_rdata + 1'b1) : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      best  <= '0;
    end else begin
      state <= state_next;
      best  <= best_next;
    end
    p   <= p_next;
    q   <= q_next;
    cur <= cur_next;
    ri  <= ri_next;
    vp  <= vp_next;
    if (start) begin
      n <= seq_len;
    end
  end

  always_comb begin
    state_next = state;
    p_next     = p;
    q_next     = q;
    cur_next   = cur;
    ri_next    = ri;
    vp_next    = vp;
    best_next  = best;
    val_raddr  = p;
    len_raddr  = q[IDX_W-1:0];
    rise_we    = 1'b0;
    fall_we    = 1'b0;
    len_wdata  = cur;
    done       = 1'b0;
    ri_use     = (state == E_F_FIRST) ? rise_rdata : ri;
    peak_sum   = (CNT_W+1)'(ri_use) + (CNT_W+1)'(len_wdata) - 1'b1;
    peak_len   = peak_sum[CNT_W-1:0];

    case (state)
      E_IDLE: begin
        if (start) begin
          p_next     = '0;
          best_next  = '0;
          state_next = E_R_HEAD;
        end
      end

      E_R_HEAD: begin
        val_raddr  = p;
        q_next     = '0;
        state_next = E_R_FIRST;
      end

      E_R_FIRST, E_R_ROW: begin
        if (state == E_R_FIRST) begin
          vp_next  = val_rdata;
          cur_next = CNT_W'(1);
          len_wdata = CNT_W'(1);
        end else begin
          cur_next  = rise_eff;
          len_wdata = rise_eff;
        end
        if (q < CNT_W'(p)) begin
          val_raddr  = q[IDX_W-1:0];
          len_raddr  = q[IDX_W-1:0];
          q_next     = CNT_W'(q + 1'b1);
          state_next = E_R_ROW;
        end else begin
          rise_we = 1'b1;
          if (CNT_W'(p) + 1'b1 == {1'b0, n}) begin
            state_next = E_F_HEAD;
          end else begin
            p_next     = IDX_W'(p + 1'b1);
            state_next = E_R_HEAD;
          end
        end
      end

      E_F_HEAD: begin
        val_raddr  = p;
        len_raddr  = p;
        q_next     = CNT_W'(p) + 1'b1;
        state_next = E_F_FIRST;
      end

      E_F_FIRST, E_F_ROW: begin
        if (state == E_F_FIRST) begin
          vp_next   = val_rdata;
          ri_next   = rise_rdata;
          cur_next  = CNT_W'(1);
          len_wdata = CNT_W'(1);
        end else begin
          cur_next  = fall_eff;
          len_wdata = fall_eff;
        end
        peak_sum = (CNT_W+1)'(ri_use) + (CNT_W+1)'(len_wdata) - 1'b1;
        peak_len = peak_sum[CNT_W-1:0];
        if (q < n) begin
          val_raddr  = q[IDX_W-1:0];
          len_raddr  = q[IDX_W-1:0];
          q_next     = CNT_W'(q + 1'b1);
          state_next = E_F_ROW;
        end else begin
          fall_we = 1'b1;
          if (ri_use > CNT_W'(1) && len_wdata > CNT_W'(1) && peak_len > best) begin
            best_next = peak_len;
          end
          if (p == '0) begin
            state_next = E_DONE;
          end else begin
            p_next     = IDX_W'(p - 1'b1);
            state_next = E_F_HEAD;
          end
        end
      end

      E_DONE: begin
        done       = 1'b1;
        state_next = E_IDLE;
      end

      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ test/mountain_checker.sv @@
// ----------------------------------------------------------------------------
// mountain_checker
// Watches the element and result channels of the mountain subsequence block.
// It rebuilds each sequence from accepted element transfers, computes the
// longest mountain with a real peak and the removal count, and compares each
// result transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mountain_checker #(
  parameter int SEQ_CAP = 64
) (
  input  logic clk,
  input  logic rst,
  mrbs_in_if   items,
  mrbs_out_if  results,
  output int   mismatches,
  output int   awaiting
);
  import mrbs_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] removals;
    logic [OUT_W-1:0] mountain_length;
    logic             overflow;
  } mountain_t;

  logic signed [VALUE_W-1:0] seq_vals [SEQ_CAP];
  int                        seq_len;
  bit                        seq_dropped;
  int                        fails;
  mountain_t                 expected_q [$];

  function automatic int longest_mountain(input int n);
    int rise [SEQ_CAP];
    int fall [SEQ_CAP];
    int best;
    best = 0;
    for (int p = 0; p < n; p++) begin
      rise[p] = 1;
      for (int q = 0; q < p; q++) begin
        if (seq_vals[q] < seq_vals[p] && rise[q] + 1 > rise[p]) rise[p] = rise[q] + 1;
      end
    end
    for (int p = n - 1; p >= 0; p--) begin
      fall[p] = 1;
      for (int q = p + 1; q < n; q++) begin
        if (seq_vals[q] < seq_vals[p] && fall[q] + 1 > fall[p]) fall[p] = fall[q] + 1;
      end
      if (rise[p] > 1 && fall[p] > 1 && rise[p] + fall[p] - 1 > best) begin
        best = rise[p] + fall[p] - 1;
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    mountain_t got;
    mountain_t want;
    int        best;
    if (rst) begin
      seq_len     = 0;
      seq_dropped = 0;
      fails       = 0;
      expected_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        got = '{results.removals, results.mountain_length, results.overflow};
        if (expected_q.size() == 0) begin
          $error("unexpected result: removals %0d mountain_length %0d overflow %0d",
                 got.removals, got.mountain_length, got.overflow);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.removals !== want.removals) begin
            $error("removals: expected %0d, actual %0d", want.removals, got.removals);
            fails++;
          end
          if (got.mountain_length !== want.mountain_length) begin
            $error("mountain_length: expected %0d, actual %0d",
                   want.mountain_length, got.mountain_length);
            fails++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
            fails++;
          end
        end
      end
      if (items.valid && items.ready) begin
        if (seq_len < SEQ_CAP) begin
          seq_vals[seq_len] = items.value;
          seq_len++;
        end else begin
          seq_dropped = 1;
        end
        if (items.last) begin
          best                 = longest_mountain(seq_len);
          want.removals        = OUT_W'(seq_len - best);
          want.mountain_length = OUT_W'(best);
          want.overflow        = seq_dropped;
          expected_q.push_back(want);
          seq_len     = 0;
          seq_dropped = 0;
        end
      end
    end
    mismatches <= fails;
    awaiting   <= expected_q.size();
  end

endmodule

@@ test/min_removals_bitonic_subsequence_tb.sv @@
// ----------------------------------------------------------------------------
// min_removals_bitonic_subsequence_tb
// Drives sequences into the mountain subsequence block: a directed set of
// edge sequences, then random sequences, mostly mountain shaped, with short,
// full and overflowing lengths. Both channels stall at random. The checker
// predicts every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module min_removals_bitonic_subsequence_tb;
  import mrbs_pkg::*;

  localparam int SEQ_CAP       = 64;
  localparam int ITEM_TARGET   = 1450;
  localparam int QUIET_LIMIT   = 30000;
  localparam int SETTLE_CYCLES = 200;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst;
  logic steady;
  int   items_sent;
  int   quiet_cycles;
  int   mismatches;
  int   awaiting;

  mrbs_in_if  items ();
  mrbs_out_if results ();

  min_removals_bitonic_subsequence #(.MAX_LEN(SEQ_CAP)) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results)
  );

  mountain_checker #(.SEQ_CAP(SEQ_CAP)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .results    (results),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    results.ready <= steady || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("min_removals_bitonic_subsequence_tb failed");
      $finish;
    end
  end

  task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
    while (!steady && $urandom_range(99) < 34) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid <= 1'b1;
    items.value <= v;
    items.last  <= is_last;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    items_sent++;
    steady <= (items_sent >= 300 && items_sent < 600);
  endtask

  // valid must already be low
  task automatic wait_drained();
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] extreme_value();
    case ($urandom_range(6))
      0:       return VAL_MIN;
      1:       return VAL_MIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return VAL_MAX - 1;
      default: return VAL_MAX;
    endcase
  endfunction

  task automatic random_sequence();
    logic signed [VALUE_W-1:0] vals [$];
    int len;
    int shape;
    int peak;
    int step;
    int base;
    int h;
    int r;
    r = $urandom_range(99);
    if (r < 4) len = $urandom_range(SEQ_CAP + 8, SEQ_CAP + 1);
    else if (r < 8) len = $urandom_range(SEQ_CAP, SEQ_CAP - 4);
    else len = $urandom_range(16, 1);
    r     = $urandom_range(99);
    shape = (r < 55) ? 2 : (r < 75) ? 0 : (r < 90) ? 1 : 3;
    peak  = $urandom_range(len - 1);
    step  = $urandom_range(1000, 1);
    base  = int'($urandom_range(2000000)) - 1000000;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: vals.push_back($urandom);
        1: vals.push_back(int'($urandom_range(16)) - 8);
        2: begin
          h = (i <= peak) ? i : 2 * peak - i;
          if ($urandom_range(99) < 8) vals.push_back(extreme_value());
          else vals.push_back(base + h * step + int'($urandom_range(2 * step)) - step);
        end
        default: vals.push_back(extreme_value());
      endcase
    end
    foreach (vals[i]) send_element(vals[i], i == vals.size() - 1);
  endtask

  initial begin
    bit paused;
    items.valid   <= 1'b0;
    items.value   <= '0;
    items.last    <= 1'b0;
    steady        <= 1'b0;
    rst           <= 1'b1;
    items_sent = 0;
    paused     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // lone element: no peak
    send_element(5, 1'b1);
    // signed extremes around a peak
    send_element(VAL_MIN, 1'b0);
    send_element(VAL_MAX, 1'b0);
    send_element(-1, 1'b1);
    // falling only
    send_element(VAL_MAX, 1'b0);
    send_element(0, 1'b0);
    send_element(VAL_MIN, 1'b1);
    // rising only
    send_element(-1, 1'b0);
    send_element(0, 1'b0);
    send_element(1, 1'b1);
    // equal values never climb
    send_element(7, 1'b0);
    send_element(7, 1'b0);
    send_element(7, 1'b1);
    // plateau at the top
    send_element(1, 1'b0);
    send_element(3, 1'b0);
    send_element(3, 1'b0);
    send_element(1, 1'b1);
    // two peaks, the wider one wins
    send_element(0, 1'b0);
    send_element(9, 1'b0);
    send_element(0, 1'b0);
    send_element(1, 1'b0);
    send_element(2, 1'b0);
    send_element(3, 1'b0);
    send_element(-5, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= 900) begin
        items.valid <= 1'b0;
        wait_drained();
        paused = 1;
      end
      random_sequence();
    end
    items.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("min_removals_bitonic_subsequence_tb passed");
    end else begin
      $display("min_removals_bitonic_subsequence_tb failed");
    end
    $finish;
  end

endmodule
